/* hdl/box_blur_3x3_edge_aware_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the box blur RTL
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH

// same-cycle implication
`define BBLUR_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBLUR_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never hold
`define BBLUR_ASSERT_NEVER(label, clk_s, rstn_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error(msg);

`endif

/* hdl/bblur_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types, widths and helper functions of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int FW_W        = 11;   // frame_width register
  localparam int FH_W        = 16;   // frame_height register
  localparam int ROW_CNT_W   = 17;   // input row counter reaches frame height plus one
  localparam int COL_SUM_W   = 10;   // three 8-bit values
  localparam int SUM_W       = 12;   // nine 8-bit values plus rounding
  localparam int NCNT_W      = 4;    // neighbour count, 1..9
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register indexes on the APB port
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  // per-item control from the front end
  typedef struct packed {
    logic emit;        // item produces a result
    logic row_above;   // row above output pixel lies in the frame
    logic row_below;   // row below lies in the frame
    logic col_left;    // column to the left lies in the frame
    logic col_right;   // column to the right lies in the frame
    logic last;        // bottom-right pixel of the frame
  } item_flags_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } result_t;

  // channel 0 = red, 1 = green, 2 = blue
  function automatic logic [CHAN_W-1:0] px_chan(input pixel_t px, input int ch);
    return px[CHAN_W*(2-ch) +: CHAN_W];
  endfunction

  // number of in-frame neighbours
  function automatic logic [NCNT_W-1:0] neighbour_count(input item_flags_t f);
    logic [1:0] rows;
    logic [1:0] cols;
    rows = 2'd1 + 2'(f.row_above) + 2'(f.row_below);
    cols = 2'd1 + 2'(f.col_left) + 2'(f.col_right);
    return NCNT_W'(rows * cols);
  endfunction

  // ceil(2^16 / n); exact floor division for dividends below 4096
  function automatic logic [RECIP_W-1:0] recip(input logic [NCNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = 17'd7282;
    endcase
    return m;
  endfunction

endpackage

/* hdl/bblur_fifo.sv */
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_aware_top_macros.svh"
// ----------------------------------------------------------------------------
// bblur_fifo
// Small synchronous register FIFO with full/empty flags.
// ----------------------------------------------------------------------------
module bblur_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import bblur_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rdata = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `BBLUR_ASSERT_NEVER(a_fifo_count, clk, rst_n, count_r > CNT_W'(DEPTH), "fifo overfilled")

endmodule

/* hdl/bblur_front.sv */
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_aware_top_macros.svh"
// ----------------------------------------------------------------------------
// bblur_front
// Accepts items, drops bubbles, tracks input and output raster positions and
// tags each item with its edge flags before it enters the work queue.
// ----------------------------------------------------------------------------
module bblur_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         push,
  output logic                         full,
  input  logic                         in_operation,
  input  logic [bblur_pkg::CHAN_W-1:0] in_red,
  input  logic [bblur_pkg::CHAN_W-1:0] in_green,
  input  logic [bblur_pkg::CHAN_W-1:0] in_blue,
  // effective frame size
  input  logic [$clog2(MAX_WIDTH):0]   w_eff,
  input  logic [bblur_pkg::FH_W-1:0]   h_eff,
  // work queue
  input  logic                         q_full,
  output logic                         q_push,
  output bblur_pkg::item_flags_t       q_flags,
  output bblur_pkg::pixel_t            q_px,
  output logic [$clog2(MAX_WIDTH)-1:0] q_idx
);
  import bblur_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = IDX_W + 1;
  localparam int ROWP_W = ROW_CNT_W + 1;

  logic [IDX_W-1:0]     in_col_r, in_col_nxt;
  logic [ROW_CNT_W-1:0] in_row_r, in_row_nxt;
  logic [IDX_W-1:0]     out_col_r, out_col_nxt;
  logic [ROW_CNT_W-1:0] out_row_r, out_row_nxt;

  logic              accept, pixel_part, bubble, started, frame_done;
  logic [WEFF_W-1:0] col_inc, ocol_inc;
  logic              col_wrap, ocol_wrap;
  logic [ROWP_W-1:0] orow_inc;
  item_flags_t       flags;

  assign full   = q_full;
  assign accept = push && !q_full;

  // classification
  always_comb begin
    pixel_part = in_row_r < ROW_CNT_W'(h_eff);
    bubble     = pixel_part && (in_operation == OP_DRAIN);
    started    = (in_row_r >= ROW_CNT_W'(2)) ||
                 ((in_row_r == ROW_CNT_W'(1)) && (in_col_r != '0));
    col_inc    = {1'b0, in_col_r} + WEFF_W'(1);
    col_wrap   = col_inc >= w_eff;
    ocol_inc   = {1'b0, out_col_r} + WEFF_W'(1);
    ocol_wrap  = ocol_inc >= w_eff;
    orow_inc   = {1'b0, out_row_r} + ROWP_W'(1);

    flags.emit      = started;
    flags.row_above = out_row_r != '0;
    flags.row_below = orow_inc < ROWP_W'(h_eff);
    flags.col_left  = out_col_r != '0;
    flags.col_right = !ocol_wrap;
    flags.last      = started && !flags.row_below && ocol_wrap;
  end

  assign frame_done = accept && !bubble && flags.last;

  // position counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept && !bubble) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_CNT_W'(1);
      end else begin
        in_col_nxt = in_col_r + IDX_W'(1);
      end
      if (started) begin
        if (flags.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (ocol_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_CNT_W'(1);
        end else begin
          out_col_nxt = out_col_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // queue entry; tail items carry a black pixel
  assign q_push  = accept && !bubble;
  assign q_flags = flags;
  assign q_px    = pixel_part ? {in_red, in_green, in_blue} : '0;
  assign q_idx   = in_col_r;

  `BBLUR_ASSERT_NEXT(a_frame_restart, clk, rst_n, frame_done, in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0, "counters not cleared after frame end")
  `BBLUR_ASSERT_NEXT(a_bubble_hold, clk, rst_n, accept && bubble, $stable(in_col_r) && $stable(in_row_r) && $stable(out_row_r), "bubble moved position")

endmodule

/* hdl/bblur_back.sv */
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_aware_top_macros.svh"
// ----------------------------------------------------------------------------
// bblur_back
// Line buffers, 3x3 window and the averaging pipeline. Stages:
//   A line buffer read, B window shift, C column sums, D row total and
//   rounding, E reciprocal multiply, then push into the result FIFO.
// ----------------------------------------------------------------------------
module bblur_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // work queue head
  input  logic                         q_empty,
  input  bblur_pkg::item_flags_t       q_flags,
  input  bblur_pkg::pixel_t            q_px,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_idx,
  output logic                         q_pop,
  // result FIFO
  input  logic                         res_full,
  output logic                         res_push,
  output bblur_pkg::result_t           res_data
);
  import bblur_pkg::*;

  localparam int IDX_W = $clog2(MAX_WIDTH);

  // line buffers: older row in the upper half, recent row in the lower half
  logic [2*PIX_W-1:0] lb_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] lb_rd_r;

  logic              adv;
  // stage A
  logic              a_valid_r;
  item_flags_t       a_flags_r;
  pixel_t            a_px_r;
  logic [IDX_W-1:0]  a_idx_r;
  // stage B: window, row 0 oldest, column 2 newest
  logic              b_valid_r;
  item_flags_t       b_flags_r;
  pixel_t            win_r [3][3];
  // stage C
  logic              c_valid_r;
  item_flags_t       c_flags_r;
  logic [COL_SUM_W-1:0] c_col_r [3][3];
  logic [COL_SUM_W-1:0] col_nxt [3][3];
  logic [NCNT_W-1:0] c_n_r;
  // stage D
  logic              d_valid_r;
  item_flags_t       d_flags_r;
  logic [SUM_W-1:0]  d_sum_r [3];
  logic [SUM_W-1:0]  sum_nxt [3];
  logic [RECIP_W-1:0] d_recip_r;
  // stage E
  logic              e_valid_r;
  item_flags_t       e_flags_r;
  logic [PROD_W-1:0] e_prod_r [3];

  // whole pipeline holds while a result waits on a full FIFO
  assign adv   = !(e_valid_r && e_flags_r.emit && res_full);
  assign q_pop = adv && !q_empty;

  // line buffer read and write-back
  always_ff @(posedge clk) begin
    if (q_pop) begin
      lb_rd_r <= lb_mem[q_idx];
    end
    if (adv && a_valid_r) begin
      lb_mem[a_idx_r] <= {lb_rd_r[PIX_W-1:0], a_px_r};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= !q_empty;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
  end

  // column sums over in-frame rows
  always_comb begin
    for (int col = 0; col < 3; col++) begin
      for (int ch = 0; ch < 3; ch++) begin
        col_nxt[col][ch] = COL_SUM_W'(px_chan(win_r[1][col], ch)) +
          (b_flags_r.row_above ? COL_SUM_W'(px_chan(win_r[0][col], ch)) : '0) +
          (b_flags_r.row_below ? COL_SUM_W'(px_chan(win_r[2][col], ch)) : '0);
      end
    end
  end

  // row total plus half the count for round-half-up
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = SUM_W'(c_col_r[1][ch]) +
        (c_flags_r.col_left  ? SUM_W'(c_col_r[0][ch]) : '0) +
        (c_flags_r.col_right ? SUM_W'(c_col_r[2][ch]) : '0) +
        SUM_W'(c_n_r >> 1);
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      a_flags_r <= q_flags;
      a_px_r    <= q_px;
      a_idx_r   <= q_idx;
      if (a_valid_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= lb_rd_r[2*PIX_W-1:PIX_W];
        win_r[1][2] <= lb_rd_r[PIX_W-1:0];
        win_r[2][2] <= a_px_r;
      end
      b_flags_r <= a_flags_r;
      c_flags_r <= b_flags_r;
      c_n_r     <= neighbour_count(b_flags_r);
      c_col_r   <= col_nxt;
      d_flags_r <= c_flags_r;
      d_recip_r <= recip(c_n_r);
      d_sum_r   <= sum_nxt;
      e_flags_r <= d_flags_r;
      for (int ch = 0; ch < 3; ch++) begin
        e_prod_r[ch] <= PROD_W'(d_sum_r[ch]) * PROD_W'(d_recip_r);
      end
    end
  end

  // quotient = product >> 16
  assign res_push       = adv && e_valid_r && e_flags_r.emit;
  assign res_data.red   = e_prod_r[0][RECIP_SHIFT +: CHAN_W];
  assign res_data.green = e_prod_r[1][RECIP_SHIFT +: CHAN_W];
  assign res_data.blue  = e_prod_r[2][RECIP_SHIFT +: CHAN_W];
  assign res_data.last  = e_flags_r.last;

  `BBLUR_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv && a_valid_r, a_valid_r && $stable(a_idx_r) && $stable(lb_rd_r), "stage A changed during stall")
  `BBLUR_ASSERT_IMPL(a_recip_set, clk, rst_n, d_valid_r && d_flags_r.emit, d_recip_r != '0, "zero reciprocal for a result")
  `BBLUR_ASSERT_IMPL(a_last_emits, clk, rst_n, e_valid_r && e_flags_r.last, e_flags_r.emit, "frame end without a result")

endmodule

/* hdl/box_blur_3x3_edge_aware_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top
// Streaming 3x3 edge-aware box blur over 24-bit RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order through push/full; an item with
// in_operation set is a drain. Drains inside the pixel part of a frame are
// dropped; after the last pixel, W+1 drains (or pixels, taken as drains)
// flush the tail. Results leave through empty/pop, oldest first, one per
// item once the item W+1 places after a pixel has arrived.
// Path: a result reaches the out_ ports from the transaction that completes
// its neighbourhood through the queue, line buffer read, window, two adder
// stages, reciprocal multiply and result FIFO.
// Throughput: one item per cycle while the result FIFO is not full; the line
// buffer memory is read and written once per item on separate cycles.
// Reset (rst_n, synchronous) clears all position counters, queues and
// pipeline valids and sets width 1024 / height 2; the line buffers are not
// cleared and need no clearing pass.
// If the receiver stops popping, the pipeline holds behind the full result
// FIFO, the 4-entry work queue fills and full rises.
// frame_width at 0x0 and frame_height at 0x4 on the APB port.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input channel
  input  logic                         push,
  output logic                         full,
  input  logic                         in_operation,
  input  logic [bblur_pkg::CHAN_W-1:0] in_red,
  input  logic [bblur_pkg::CHAN_W-1:0] in_green,
  input  logic [bblur_pkg::CHAN_W-1:0] in_blue,
  // result channel
  output logic                         empty,
  input  logic                         pop,
  output logic [bblur_pkg::CHAN_W-1:0] out_blur_red,
  output logic [bblur_pkg::CHAN_W-1:0] out_blur_green,
  output logic [bblur_pkg::CHAN_W-1:0] out_blur_blue,
  output logic                         out_last_of_frame
);
  import bblur_pkg::*;

  localparam int IDX_W   = $clog2(MAX_WIDTH);
  localparam int WEFF_W  = IDX_W + 1;
  localparam int QDEPTH  = 4;
  localparam int ODEPTH  = 2;
  localparam int FLAGS_W = $bits(item_flags_t);
  localparam int Q_W     = FLAGS_W + PIX_W + IDX_W;

  logic [FW_W-1:0]   frame_width_r, frame_width_nxt;
  logic [FH_W-1:0]   frame_height_r, frame_height_nxt;
  logic [WEFF_W-1:0] w_eff;
  logic [FH_W-1:0]   h_eff;
  logic              cfg_wr;

  logic              q_push, q_full, q_pop, q_empty;
  item_flags_t       fq_flags, bq_flags;
  pixel_t            fq_px, bq_px;
  logic [IDX_W-1:0]  fq_idx, bq_idx;
  logic [Q_W-1:0]    q_rdata;

  logic              res_push, res_full;
  result_t           res_wdata, res_rdata;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr) begin
      case (paddr[2])
        CFG_IDX_WIDTH:  frame_width_nxt  = pwdata[FW_W-1:0];
        CFG_IDX_HEIGHT: frame_height_nxt = pwdata[FH_W-1:0];
        default:        frame_width_nxt  = frame_width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(1024);
      frame_height_r <= FH_W'(2);
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  // register read-back
  always_comb begin
    case (paddr[2])
      CFG_IDX_WIDTH:  prdata = 32'(frame_width_r);
      CFG_IDX_HEIGHT: prdata = 32'(frame_height_r);
      default:        prdata = '0;
    endcase
  end

  // clamped frame size
  always_comb begin
    if (frame_width_r < FW_W'(2)) begin
      w_eff = WEFF_W'(2);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(frame_width_r);
    end
    h_eff = (frame_height_r < FH_W'(2)) ? FH_W'(2) : frame_height_r;
  end

  // front end
  bblur_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_flags      (fq_flags),
    .q_px         (fq_px),
    .q_idx        (fq_idx)
  );

  // work queue between front and back
  bblur_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QDEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_push),
    .wdata ({fq_flags, fq_px, fq_idx}),
    .full  (q_full),
    .rd_en (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {bq_flags, bq_px, bq_idx} = q_rdata;

  // back end
  bblur_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_flags  (bq_flags),
    .q_px     (bq_px),
    .q_idx    (bq_idx),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_wdata)
  );

  // result FIFO
  bblur_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (ODEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .rd_en (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign out_blur_red      = res_rdata.red;
  assign out_blur_green    = res_rdata.green;
  assign out_blur_blue     = res_rdata.blue;
  assign out_last_of_frame = res_rdata.last;

endmodule

/* bench/blur_result_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_result_check
// Watches the push, pop and register ports of the 3x3 edge-aware box blur,
// keeps its own copy of the line buffers, window and frame position, works
// out the blurred pixel that each accepted transaction completes, if any, and
// compares every popped result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module blur_result_check
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              push,
  input  logic              full,
  input  logic              in_operation,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_blue,
  input  logic              empty,
  input  logic              pop,
  input  logic [CHAN_W-1:0] out_blur_red,
  input  logic [CHAN_W-1:0] out_blur_green,
  input  logic [CHAN_W-1:0] out_blur_blue,
  input  logic              out_last_of_frame,
  output int                fail_count,
  output int                outstanding
);

  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  pixel_t          older_line  [MAX_WIDTH];
  pixel_t          recent_line [MAX_WIDTH];
  pixel_t          nbr_win     [3][3];
  int unsigned     in_col, in_row, out_col, out_row;
  result_t         pending_blur [$];
  int              errors = 0;

  // advance the blur state by one transaction, queue the pixel it completes
  task automatic predict_blur(input logic op, input pixel_t px_in);
    int unsigned ew, eh, slot, n, ro, co;
    int unsigned sum_r, sum_g, sum_b;
    pixel_t      px, v;
    bit          started, frame_end;
    bit          row_ok [3];
    bit          col_ok [3];
    result_t     res;
    int          r, c;
    ew = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    eh = (height_reg < 2) ? 2 : height_reg;
    px = '0;
    // drains in the pixel part are bubbles; anything in the tail is a drain
    if (in_row < eh) begin
      if (op == OP_DRAIN) return;
      px = px_in;
    end
    started = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    slot = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;

    // shift window left, bring in the new column from the line buffers
    for (r = 0; r < 3; r++) begin
      nbr_win[r][0] = nbr_win[r][1];
      nbr_win[r][1] = nbr_win[r][2];
    end
    nbr_win[0][2] = older_line[slot];
    nbr_win[1][2] = recent_line[slot];
    nbr_win[2][2] = px;
    older_line[slot]  = recent_line[slot];
    recent_line[slot] = px;

    if (in_col + 1 >= ew) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (!started) return;

    // average over in-frame neighbours only
    ro = out_row;
    co = out_col;
    row_ok[0] = ro > 0;
    row_ok[1] = 1'b1;
    row_ok[2] = ro + 1 < eh;
    col_ok[0] = co > 0;
    col_ok[1] = 1'b1;
    col_ok[2] = co + 1 < ew;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n = 0;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          v = nbr_win[r][c];
          sum_r += v[23:16];
          sum_g += v[15:8];
          sum_b += v[7:0];
          n++;
        end
      end
    end
    // round half up
    res.red   = CHAN_W'((sum_r + n / 2) / n);
    res.green = CHAN_W'((sum_g + n / 2) / n);
    res.blue  = CHAN_W'((sum_b + n / 2) / n);
    frame_end = (ro + 1 >= eh) && (co + 1 >= ew);
    res.last  = frame_end;
    pending_blur.push_back(res);

    if (frame_end) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else if (co + 1 >= ew) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    int      i;
    if (!rst_n) begin
      width_reg  = FW_W'(1024);
      height_reg = FH_W'(2);
      for (i = 0; i < MAX_WIDTH; i++) begin
        older_line[i]  = '0;
        recent_line[i] = '0;
      end
      for (i = 0; i < 9; i++) nbr_win[i / 3][i % 3] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      pending_blur.delete();
    end else begin
      // result transaction against the oldest expectation
      if (pop && !empty) begin
        got.red   = out_blur_red;
        got.green = out_blur_green;
        got.blue  = out_blur_blue;
        got.last  = out_last_of_frame;
        if (pending_blur.size() == 0) begin
          errors++;
          $error("result popped with no blurred pixel expected");
        end else begin
          want = pending_blur.pop_front();
          if (got.red !== want.red) begin
            errors++;
            $error("blur_red: expected %0d, got %0d", want.red, got.red);
          end
          if (got.green !== want.green) begin
            errors++;
            $error("blur_green: expected %0d, got %0d", want.green, got.green);
          end
          if (got.blue !== want.blue) begin
            errors++;
            $error("blur_blue: expected %0d, got %0d", want.blue, got.blue);
          end
          if (got.last !== want.last) begin
            errors++;
            $error("last_of_frame: expected %0d, got %0d", want.last, got.last);
          end
        end
      end
      // register write on the APB access cycle
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == CFG_IDX_WIDTH) width_reg = pwdata[FW_W-1:0];
        else height_reg = pwdata[FH_W-1:0];
      end
      if (push && !full) predict_blur(in_operation, {in_red, in_green, in_blue});
    end
    fail_count  <= errors;
    outstanding <= pending_blur.size();
  end

endmodule

/* bench/box_blur_3x3_edge_aware_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top_tb
// Drives pixel frames through the edge-aware box blur and gives the verdict.
// A short hand-built part covers saturated and zero channels, rounding, a
// bubble inside the frame, a pixel in the flush tail and clamped register
// values. A full-width frame then fills every line buffer entry, after which
// the registers are also changed part way through frames. The rest is
// random small frames with random bubbles, tails and occasional short tails,
// with random gaps on both sides. Checking sits in blur_result_check.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top_tb;
  import bblur_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PIPE_FLUSH   = 16;    // pipeline depth plus work queue, with margin
  localparam int STALL_LIMIT  = 2000;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [2:0]        paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              push         = 1'b0;
  logic              full;
  logic              in_operation = OP_PIXEL;
  logic [CHAN_W-1:0] in_red       = '0;
  logic [CHAN_W-1:0] in_green     = '0;
  logic [CHAN_W-1:0] in_blue      = '0;
  logic              empty;
  logic              pop          = 1'b0;
  logic [CHAN_W-1:0] out_blur_red;
  logic [CHAN_W-1:0] out_blur_green;
  logic [CHAN_W-1:0] out_blur_blue;
  logic              out_last_of_frame;

  int fail_count;
  int outstanding;
  int idle_cycles  = 0;
  int rx_hold      = 0;
  int random_items = 0;
  int cfg_width    = 1024;
  int cfg_height   = 2;
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;

  box_blur_3x3_edge_aware_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .in_operation     (in_operation),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .empty            (empty),
    .pop              (pop),
    .out_blur_red     (out_blur_red),
    .out_blur_green   (out_blur_green),
    .out_blur_blue    (out_blur_blue),
    .out_last_of_frame(out_last_of_frame)
  );

  blur_result_check #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_blur_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .in_operation     (in_operation),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .empty            (empty),
    .pop              (pop),
    .out_blur_red     (out_blur_red),
    .out_blur_green   (out_blur_green),
    .out_blur_blue    (out_blur_blue),
    .out_last_of_frame(out_last_of_frame),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly no pause, some short ones, a few long
  function automatic int pick_pause(input bit quiet);
    int roll;
    roll = $urandom_range(99);
    if (quiet || roll < 65) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(50, 12);
  endfunction

  // channel value, biased towards the extremes now and then
  function automatic logic [CHAN_W-1:0] random_channel();
    if ($urandom_range(99) < 15) return $urandom_range(1) ? 8'hFF : 8'h00;
    return CHAN_W'($urandom);
  endfunction

  // receiver: random stalls, with quiet stretches that pop every cycle
  always @(posedge clk) begin
    if ($urandom_range(299) == 0) rx_quiet = !rx_quiet;
    if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      rx_hold = pick_pause(rx_quiet);
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input transaction, after a random gap
  task automatic send_item(input logic op, input logic [CHAN_W-1:0] r,
                           input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
    int gap;
    gap = pick_pause(tx_quiet);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_operation <= op;
    in_red       <= r;
    in_green     <= g;
    in_blue      <= b;
    do @(posedge clk); while (full);
  endtask

  // hold off until every expected result is out and the pipeline is empty
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  // APB write: setup, access, then the bus returns to idle
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == CFG_IDX_WIDTH) cfg_width = value;
    else cfg_height = value;
  endtask

  // raster frame with random bubbles, then the flush tail
  task automatic send_frame(input int w, input int h, input bit short_tail);
    int p, n_tail;
    tx_quiet = ($urandom_range(7) == 0);
    for (p = 0; p < w * h; p++) begin
      if ($urandom_range(99) < 6)
        send_item(OP_DRAIN, random_channel(), random_channel(), random_channel());
      send_item(OP_PIXEL, random_channel(), random_channel(), random_channel());
    end
    // a broken frame stops the tail early and runs into the next one
    n_tail = short_tail ? $urandom_range(w) : w + 1;
    for (p = 0; p < n_tail; p++)
      send_item(($urandom_range(4) == 0) ? OP_PIXEL : OP_DRAIN,
                random_channel(), random_channel(), random_channel());
  endtask

  // start a frame with one setting, change it part way through, then finish
  task automatic cut_frame(input int w1, h1, n_first, w2, h2, n_second);
    int p;
    settle();
    write_reg(CFG_IDX_WIDTH, w1);
    write_reg(CFG_IDX_HEIGHT, h1);
    for (p = 0; p < n_first; p++)
      send_item(OP_PIXEL, random_channel(), random_channel(), random_channel());
    settle();
    write_reg(CFG_IDX_WIDTH, w2);
    write_reg(CFG_IDX_HEIGHT, h2);
    for (p = 0; p < n_second; p++)
      send_item(OP_PIXEL, random_channel(), random_channel(), random_channel());
    for (p = 0; p <= w2; p++)
      send_item(OP_DRAIN, random_channel(), random_channel(), random_channel());
  endtask

  initial begin
    int p, w, h, ew, eh, frames, f;
    bit wr_w, wr_h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame: checkerboard red, saturated green, lone blue for rounding
    write_reg(CFG_IDX_WIDTH, 32'd3);
    write_reg(CFG_IDX_HEIGHT, 32'd3);
    for (p = 0; p < 9; p++) begin
      send_item(OP_PIXEL, p[0] ? 8'hFF : 8'h00, 8'hFF, (p == 4) ? 8'h02 : 8'h00);
      if (p == 4) send_item(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);   // bubble mid-frame
    end
    // tail, with a pixel that must be taken as a drain
    send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_DRAIN, 8'h55, 8'hAA, 8'h55);
    send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);

    // width and height below range, both used as 2
    settle();
    write_reg(CFG_IDX_WIDTH, 32'd1);
    write_reg(CFG_IDX_HEIGHT, 32'd0);
    for (p = 0; p < 4; p++) begin
      w = (p == 0 || p == 3) ? 8'hFF : 8'h00;
      send_item(OP_PIXEL, w, w, w);
    end
    for (p = 0; p < 3; p++) send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);

    // width above range (1024 used), height 1: writes every line buffer entry
    settle();
    write_reg(CFG_IDX_WIDTH, 32'd2047);
    write_reg(CFG_IDX_HEIGHT, 32'd1);
    send_frame(MAX_WIDTH, 2, 1'b0);

    // tallest frame cut short, then the widest frame narrowed mid-row
    cut_frame(2, 65535, 12, 2, 3, 0);
    cut_frame(MAX_WIDTH, 2, 40, 4, 2, 4);

    // random small frames, new setting between groups of frames
    while (random_items < RANDOM_ITEMS) begin
      settle();
      p = $urandom_range(99);
      w = (p < 5) ? $urandom_range(1) : ((p < 85) ? $urandom_range(8, 2) : $urandom_range(40, 9));
      h = ($urandom_range(99) < 5) ? $urandom_range(1) : $urandom_range(6, 2);
      wr_w = ($urandom_range(3) != 0);
      wr_h = ($urandom_range(3) != 0);
      if (!wr_w && !wr_h) wr_w = 1'b1;
      if (wr_w) write_reg(CFG_IDX_WIDTH, w);
      if (wr_h) write_reg(CFG_IDX_HEIGHT, h);
      ew = (cfg_width < 2) ? 2 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
      eh = (cfg_height < 2) ? 2 : cfg_height;
      frames = $urandom_range(3, 1);
      for (f = 0; f < frames; f++) begin
        send_frame(ew, eh, $urandom_range(19) == 0);
        random_items += ew * eh + ew + 1;
      end
    end

    settle();
    if (fail_count == 0 && outstanding == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
